/* hdl/tup_pkg.sv */
package tup_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } char_t;

  typedef struct packed {
    logic [31:0] value;
    logic        overflowed;
    logic        digits_seen;
  } result_t;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_HEX    = 3'd4,
    PH_DIGITS = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE   = 2'd0,
    DS_DIGITS = 2'd1,
    DS_OVER   = 2'd2
  } digit_status_t;

  localparam logic [4:0] RADIX_NONE = 5'd0;
  localparam logic [4:0] RADIX_OCT  = 5'd8;
  localparam logic [4:0] RADIX_DEC  = 5'd10;
  localparam logic [4:0] RADIX_HEX  = 5'd16;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] UP_BASE  = 8'h37;
  localparam logic [7:0] LO_BASE  = 8'h57;

endpackage

/* hdl/text_to_unsigned32_parser.sv */
// A result word is registered: res_valid rises in the cycle after the character that ends the number is taken.
// Throughput: one character per cycle; char_ready stays high while the result
// register is empty or being taken in the same cycle.
// Reset (rst, synchronous): the parser returns to the done phase, ignoring
// characters until one arrives with first set, and the result register empties.
module text_to_unsigned32_parser
  import tup_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    char_valid,
  output logic    char_ready,
  input  char_t   char_word,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_word
);

  phase_t        phase, phase_next;
  logic          negative, negative_next;
  logic [4:0]    radix, radix_next;
  logic [31:0]   accumulator, accumulator_next;
  digit_status_t digit_status, digit_status_next;

  phase_t        ph_cur;
  logic          neg_cur;
  logic [4:0]    radix_cur;
  logic [31:0]   acc_cur;
  digit_status_t ds_cur;

  logic [7:0]  c;
  logic        is_space, is_sign, is_zero, is_x;
  logic        is_num, is_up, is_lo;
  logic [7:0]  dig_wide;
  logic [5:0]  dig;
  logic        alnum;
  logic [4:0]  take_radix;
  logic        take;
  logic        dig_ok;
  logic [37:0] prod;
  logic        emit;
  result_t     result;
  logic        char_fire;

  assign char_ready = !res_valid || res_ready;
  assign char_fire  = char_valid && char_ready;
  assign c          = char_word.ch;

  always_comb begin
    ph_cur    = char_word.first ? PH_SPACE : phase;
    neg_cur   = char_word.first ? 1'b0 : negative;
    radix_cur = char_word.first ? RADIX_NONE : radix;
    acc_cur   = char_word.first ? 32'd0 : accumulator;
    ds_cur    = char_word.first ? DS_NONE : digit_status;
  end

  always_comb begin
    is_space = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    is_sign  = (c == CH_MINUS) || (c == CH_PLUS);
    is_zero  = (c == CH_ZERO);
    is_x     = (c == CH_X_LO) || (c == CH_X_UP);
    is_num   = (c >= CH_ZERO) && (c <= CH_NINE);
    is_up    = (c >= CH_A_UP) && (c <= CH_Z_UP);
    is_lo    = (c >= CH_A_LO) && (c <= CH_Z_LO);
    alnum    = is_num || is_up || is_lo;
    if (is_num) begin
      dig_wide = c - CH_ZERO;
    end else if (is_up) begin
      dig_wide = c - UP_BASE;
    end else begin
      dig_wide = c - LO_BASE;
    end
    dig = dig_wide[5:0];
  end

  // select the radix for this character and whether it goes to the digit path
  always_comb begin
    take       = 1'b0;
    take_radix = radix_cur;
    case (ph_cur)
      PH_SPACE: begin
        if (!is_space && !is_sign && !is_zero) begin
          take       = 1'b1;
          take_radix = RADIX_DEC;
        end
      end
      PH_SIGNED: begin
        if (!is_zero) begin
          take       = 1'b1;
          take_radix = RADIX_DEC;
        end
      end
      PH_ZERO: begin
        if (!is_x) begin
          take       = 1'b1;
          take_radix = RADIX_OCT;
        end
      end
      PH_HEX, PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  assign dig_ok = alnum && ({1'b0, take_radix} > dig);
  assign prod   = {6'd0, acc_cur} * {33'd0, take_radix} + {32'd0, dig};

  always_comb begin
    phase_next        = ph_cur;
    negative_next     = neg_cur;
    radix_next        = radix_cur;
    accumulator_next  = acc_cur;
    digit_status_next = ds_cur;
    case (ph_cur)
      PH_SPACE, PH_SIGNED: begin
        if (ph_cur == PH_SPACE && is_space) begin
          phase_next = PH_SPACE;
        end else if (ph_cur == PH_SPACE && is_sign) begin
          negative_next = (c == CH_MINUS);
          phase_next    = PH_SIGNED;
        end else if (is_zero) begin
          digit_status_next = DS_DIGITS;
          accumulator_next  = 32'd0;
          phase_next        = PH_ZERO;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          radix_next = RADIX_HEX;
          phase_next = PH_HEX;
        end
      end
      PH_HEX, PH_DIGITS: begin
        phase_next = ph_cur;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
    if (take) begin
      radix_next = take_radix;
      if (dig_ok) begin
        phase_next = PH_DIGITS;
        if (ds_cur != DS_OVER) begin
          if (prod[37:32] != 6'd0) begin
            digit_status_next = DS_OVER;
            accumulator_next  = '1;
          end else begin
            digit_status_next = DS_DIGITS;
            accumulator_next  = prod[31:0];
          end
        end
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  always_comb begin
    emit               = take && !dig_ok;
    result.overflowed  = (ds_cur == DS_OVER);
    result.digits_seen = (ds_cur != DS_NONE);
    if (ds_cur == DS_OVER) begin
      result.value = '1;
    end else if (neg_cur) begin
      result.value = 32'd0 - acc_cur;
    end else begin
      result.value = acc_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DONE;
      negative     <= 1'b0;
      radix        <= RADIX_NONE;
      accumulator  <= 32'd0;
      digit_status <= DS_NONE;
    end else if (char_fire) begin
      phase        <= phase_next;
      negative     <= negative_next;
      radix        <= radix_next;
      accumulator  <= accumulator_next;
      digit_status <= digit_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (char_fire && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_fire && emit) begin
      res_word <= result;
    end
  end

  a_over_saturates: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res_word.overflowed ||
                   (res_word.digits_seen && res_word.value == 32'hFFFF_FFFF)))
    else $error("overflowed result not saturated");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (char_fire && emit) |=> (phase == PH_DONE))
    else $error("parser not done after result");

  a_acc_saturated: assert property (@(posedge clk) disable iff (rst)
    (digit_status == DS_OVER) |-> (accumulator == 32'hFFFF_FFFF))
    else $error("accumulator not saturated in overflow");

  a_digits_radix: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DIGITS) |-> ((radix == RADIX_OCT || radix == RADIX_DEC ||
                               radix == RADIX_HEX) && digit_status != DS_NONE))
    else $error("digit phase without radix or digits");

endmodule
